### rtl/core/cfa_pkg.sv
// cfa_pkg: shared constants, codes, state types and the control/status structs
// of the contiguous frame allocator. no dependencies; used by every other file but cfa_ram.
`default_nettype none

package cfa_pkg;

  localparam int MAX_FRAMES        = 16384;
  localparam int FRAME_NUMBER_BITS = 20;
  localparam int COUNT_BITS        = 15;
  localparam int STATUS_BITS       = 3;
  localparam int REQ_BITS          = 2;
  localparam int CFG_IDX_BITS      = 2;
  localparam int CFG_DATA_BITS     = FRAME_NUMBER_BITS;

  localparam int IDX_BITS  = $clog2(MAX_FRAMES);
  localparam int FPW       = 8;
  localparam int LANE_BITS = $clog2(FPW);
  localparam int WORDS     = MAX_FRAMES / FPW;
  localparam int WORD_BITS = IDX_BITS - LANE_BITS;
  localparam int ST_BITS   = 2;
  localparam int WORD_W    = FPW * ST_BITS;

  localparam int CMP_MAX1 = (FRAME_NUMBER_BITS > COUNT_BITS) ? FRAME_NUMBER_BITS : COUNT_BITS;
  localparam int CMP_MAX2 = (CMP_MAX1 > IDX_BITS) ? CMP_MAX1 : IDX_BITS;
  localparam int CMP_BITS = CMP_MAX2 + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [ST_BITS-1:0] ST_FREE = 2'd0;
  localparam logic [ST_BITS-1:0] ST_HEAD = 2'd1;
  localparam logic [ST_BITS-1:0] ST_USED = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POOL = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INFO = 2'd2;

  localparam logic [FRAME_NUMBER_BITS-1:0] BASE_RESET = '0;
  localparam logic [COUNT_BITS-1:0]        POOL_RESET = COUNT_BITS'(MAX_FRAMES);
  localparam logic                         INFO_RESET = 1'b1;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_RESERVE = 2'd2,
    REQ_INIT    = 2'd3
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK      = 3'd0,
    STAT_NOSPACE = 3'd1,
    STAT_NOTFREE = 3'd2,
    STAT_NOTHEAD = 3'd3,
    STAT_RANGE   = 3'd4
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_MARK_SETUP,
    S_MARK,
    S_RELEASE,
    S_INIT,
    S_FINISH
  } cfa_state_t;

  typedef enum logic [1:0] {
    SW_INIT,
    SW_SCAN,
    SW_MARK,
    SW_RELEASE
  } sweep_mode_t;

  typedef struct packed {
    logic        load;
    logic        decide;
    logic        mark_setup;
    logic        step;
    logic        sweep;
    sweep_mode_t mode;
    logic        finish;
  } cfa_cmd_t;

  typedef struct packed {
    req_t req;
    logic pre_done;
    logic done;
    logic found;
    logic out_busy;
  } cfa_sts_t;

endpackage

`default_nettype wire

### rtl/core/cfa_ifs.sv
// cfa_ifs: valid/ready channel interfaces for request items, result items and
// configuration writes. depends on cfa_pkg.
`default_nettype none

interface cfa_in_if;
  import cfa_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [REQ_BITS-1:0]          req_type;
  logic [FRAME_NUMBER_BITS-1:0] frame_no;
  logic [COUNT_BITS-1:0]        count;
  modport source (output valid, req_type, frame_no, count, input ready);
  modport sink   (input valid, req_type, frame_no, count, output ready);
endinterface

interface cfa_out_if;
  import cfa_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [STATUS_BITS-1:0]       status;
  logic [FRAME_NUMBER_BITS-1:0] result_frame;
  logic [COUNT_BITS-1:0]        free_left;
  modport source (output valid, status, result_frame, free_left, input ready);
  modport sink   (input valid, status, result_frame, free_left, output ready);
endinterface

interface cfa_cfg_if;
  import cfa_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/cfa_ram.sv
// cfa_ram: generic simple dual-port ram, one write and one registered read port.
// no dependencies.
`default_nettype none

module cfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/cfa_ctrl.sv
// cfa_ctrl: request sequencer; steps each item through check, sweep and result.
// depends on cfa_pkg and cfa_ifs; drives cfa_dpath through cfa_cmd_t.
`default_nettype none

module cfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  cfa_in_if.sink            in_ch,
  output cfa_pkg::cfa_cmd_t cmd,
  input  cfa_pkg::cfa_sts_t sts
);
  import cfa_pkg::*;

  cfa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.pre_done) begin
          state_nxt = S_FINISH;
        end else begin
          case (sts.req)
            REQ_ALLOC:   state_nxt = S_SCAN;
            REQ_RELEASE: state_nxt = S_RELEASE;
            REQ_RESERVE: state_nxt = S_MARK_SETUP;
            REQ_INIT:    state_nxt = S_INIT;
            default:     state_nxt = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.done) begin
          state_nxt = sts.found ? S_MARK_SETUP : S_FINISH;
        end
      end
      S_MARK_SETUP: state_nxt = S_MARK;
      S_MARK, S_RELEASE, S_INIT: begin
        if (sts.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready    = 1'b0;
    cmd            = '0;
    cmd.mode       = SW_INIT;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        cmd.load    = in_ch.valid;
      end
      S_DECIDE:     cmd.decide = 1'b1;
      S_SCAN: begin
        cmd.step  = 1'b1;
        cmd.sweep = 1'b1;
        cmd.mode  = SW_SCAN;
      end
      S_MARK_SETUP: cmd.mark_setup = 1'b1;
      S_MARK: begin
        cmd.step  = 1'b1;
        cmd.sweep = 1'b1;
        cmd.mode  = SW_MARK;
      end
      S_RELEASE: begin
        cmd.step  = 1'b1;
        cmd.sweep = 1'b1;
        cmd.mode  = SW_RELEASE;
      end
      S_INIT: begin
        cmd.step  = 1'b1;
        cmd.sweep = 1'b1;
        cmd.mode  = SW_INIT;
      end
      S_FINISH:     cmd.finish = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/cfa_dpath.sv
// cfa_dpath: configuration registers, request registers, frame-state ram sweep
// engine, free count and result register. depends on cfa_pkg, cfa_ifs, cfa_ram.
`default_nettype none

module cfa_dpath (
  input  logic              clk,
  input  logic              rst_n,
  cfa_in_if.sink            in_ch,
  cfa_out_if.source         out_ch,
  cfa_cfg_if.sink           cfg_ch,
  input  cfa_pkg::cfa_cmd_t cmd,
  output cfa_pkg::cfa_sts_t sts
);
  import cfa_pkg::*;

  // configuration
  logic [FRAME_NUMBER_BITS-1:0] base_r, base_nxt;
  logic [COUNT_BITS-1:0]        pool_r, pool_nxt;
  logic                         info_r, info_nxt;
  logic [COUNT_BITS-1:0]        n_c;

  // request
  req_t                         req_r, req_nxt;
  logic [FRAME_NUMBER_BITS-1:0] fno_r, fno_nxt;
  logic [COUNT_BITS-1:0]        cnt_r, cnt_nxt;
  logic [IDX_BITS-1:0]          rel_r, rel_nxt;
  logic                         inr_r, inr_nxt;
  logic [CMP_BITS-1:0]          diff_c;

  // sweep and bookkeeping
  logic [COUNT_BITS-1:0]        free_r, free_nxt;
  stat_t                        status_r, status_nxt;
  logic [COUNT_BITS-1:0]        run_r, run_nxt;
  logic [IDX_BITS-1:0]          start_r, start_nxt;
  logic                         act_r, act_nxt;
  logic [COUNT_BITS-1:0]        end_r, end_nxt;
  logic [WORD_BITS-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [WORD_BITS-1:0]         pw_r, pw_nxt;
  logic                         pv_r, pv_nxt;
  logic [CMP_BITS-1:0]          end_sum_c;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  stat_t                        out_status_r, out_status_nxt;
  logic [FRAME_NUMBER_BITS-1:0] out_frame_r, out_frame_nxt;
  logic [COUNT_BITS-1:0]        out_free_r, out_free_nxt;

  // checks and word processing
  stat_t                        pre_stat_c;
  logic                         pre_skip_c;
  logic [WORD_W-1:0]            rd_data;
  logic [WORD_W-1:0]            wdata_c;
  logic                         wr_en_c;
  logic                         proc_en_c;
  logic [ST_BITS-1:0]           st_c [FPW];
  logic [IDX_BITS-1:0]          lane_f_c [FPW];
  logic [FPW-1:0]               lane_in_c;
  logic [CMP_BITS-1:0]          word_end_c;
  logic                         word_done_c;
  logic                         found_c;
  logic                         blocked_c;
  logic [COUNT_BITS-1:0]        run_c;
  logic [IDX_BITS-1:0]          start_c;
  logic                         act_c;
  logic [LANE_BITS:0]           k_c;
  logic [COUNT_BITS:0]          free_sum_c;
  logic [COUNT_BITS-1:0]        free_fin_c;
  logic [FRAME_NUMBER_BITS-1:0] res_c;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    n_c = (int'(pool_r) > MAX_FRAMES) ? COUNT_BITS'(MAX_FRAMES) : pool_r;
  end

  always_comb begin
    base_nxt = base_r;
    pool_nxt = pool_r;
    info_nxt = info_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_BASE: base_nxt = FRAME_NUMBER_BITS'(cfg_ch.data);
        CFG_POOL: pool_nxt = cfg_ch.data[COUNT_BITS-1:0];
        CFG_INFO: info_nxt = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // request capture, relative frame index and range check
  always_comb begin
    diff_c  = CMP_BITS'(in_ch.frame_no) - CMP_BITS'(base_r);
    req_nxt = req_r;
    fno_nxt = fno_r;
    cnt_nxt = cnt_r;
    rel_nxt = rel_r;
    inr_nxt = inr_r;
    if (cmd.load) begin
      req_nxt = req_t'(in_ch.req_type);
      fno_nxt = in_ch.frame_no;
      cnt_nxt = in_ch.count;
      rel_nxt = IDX_BITS'(diff_c);
      inr_nxt = (in_ch.frame_no >= base_r) && (diff_c < CMP_BITS'(n_c));
    end
  end

  always_comb begin
    pre_stat_c = STAT_OK;
    pre_skip_c = 1'b0;
    case (req_r)
      REQ_ALLOC: begin
        if (cnt_r == '0) begin
          pre_stat_c = STAT_RANGE;
        end else if ((cnt_r > free_r) || (cnt_r > n_c)) begin
          pre_stat_c = STAT_NOSPACE;
        end
      end
      REQ_RESERVE: begin
        if ((cnt_r == '0) || !inr_r) begin
          pre_stat_c = STAT_RANGE;
        end
      end
      REQ_RELEASE: begin
        if (!inr_r) begin
          pre_stat_c = STAT_RANGE;
        end
      end
      REQ_INIT: pre_skip_c = (n_c == '0);
      default: ;
    endcase
  end

  cfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en_c),
    .wr_addr (pw_r),
    .wr_data (wdata_c),
    .rd_en   (cmd.step),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  always_comb begin
    for (int j = 0; j < FPW; j++) begin
      st_c[j]      = rd_data[j*ST_BITS +: ST_BITS];
      lane_f_c[j]  = {pw_r, LANE_BITS'(j)};
      lane_in_c[j] = CMP_BITS'(lane_f_c[j]) < CMP_BITS'(n_c);
    end
    word_end_c = CMP_BITS'({pw_r, {LANE_BITS{1'b1}}}) + CMP_BITS'(1);
  end

  // one ram word per cycle: scan for a free run, or read-modify-write a run or the pool
  always_comb begin
    proc_en_c   = pv_r && cmd.sweep;
    wdata_c     = rd_data;
    wr_en_c     = 1'b0;
    word_done_c = 1'b0;
    found_c     = 1'b0;
    blocked_c   = 1'b0;
    run_c       = run_r;
    start_c     = start_r;
    act_c       = act_r;
    k_c         = '0;
    case (cmd.mode)
      SW_INIT: begin
        for (int j = 0; j < FPW; j++) begin
          if (lane_in_c[j]) begin
            wdata_c[j*ST_BITS +: ST_BITS] =
                ((lane_f_c[j] == '0) && info_r) ? ST_HEAD : ST_FREE;
          end
        end
        wr_en_c     = proc_en_c;
        word_done_c = word_end_c >= CMP_BITS'(n_c);
      end
      SW_SCAN: begin
        for (int j = 0; j < FPW; j++) begin
          if (!found_c) begin
            if (lane_in_c[j] && (st_c[j] == ST_FREE)) begin
              if (run_c == '0) begin
                start_c = lane_f_c[j];
              end
              run_c = run_c + COUNT_BITS'(1);
              if (run_c == cnt_r) begin
                found_c = 1'b1;
              end
            end else begin
              run_c = '0;
            end
          end
        end
        word_done_c = found_c || (word_end_c >= CMP_BITS'(n_c));
      end
      SW_MARK: begin
        if ((req_r == REQ_RESERVE) && (pw_r == start_r[IDX_BITS-1:LANE_BITS])
            && (st_c[start_r[LANE_BITS-1:0]] != ST_FREE)) begin
          blocked_c = 1'b1;
        end
        for (int j = 0; j < FPW; j++) begin
          if (lane_f_c[j] == start_r) begin
            wdata_c[j*ST_BITS +: ST_BITS] = ST_HEAD;
          end else if ((lane_f_c[j] > start_r)
                       && (CMP_BITS'(lane_f_c[j]) < CMP_BITS'(end_r))) begin
            wdata_c[j*ST_BITS +: ST_BITS] = ST_USED;
          end
        end
        wr_en_c     = proc_en_c && !blocked_c;
        word_done_c = blocked_c || (word_end_c >= CMP_BITS'(end_r));
      end
      SW_RELEASE: begin
        for (int j = 0; j < FPW; j++) begin
          if (lane_f_c[j] == rel_r) begin
            if (st_c[j] != ST_HEAD) begin
              blocked_c = 1'b1;
              act_c     = 1'b0;
            end else begin
              wdata_c[j*ST_BITS +: ST_BITS] = ST_FREE;
              k_c = k_c + (LANE_BITS+1)'(1);
            end
          end else if ((lane_f_c[j] > rel_r) && act_c) begin
            if (lane_in_c[j] && (st_c[j] != ST_FREE) && (st_c[j] != ST_HEAD)) begin
              wdata_c[j*ST_BITS +: ST_BITS] = ST_FREE;
              k_c = k_c + (LANE_BITS+1)'(1);
            end else begin
              act_c = 1'b0;
            end
          end
        end
        wr_en_c     = proc_en_c && !blocked_c;
        word_done_c = !act_c || (word_end_c >= CMP_BITS'(n_c));
      end
      default: ;
    endcase
  end

  always_comb begin
    free_sum_c = {1'b0, free_r} + (COUNT_BITS+1)'(k_c);
    end_sum_c  = CMP_BITS'(start_r) + CMP_BITS'(cnt_r);
    free_fin_c = free_r;
    res_c      = '0;
    case (req_r)
      REQ_INIT: begin
        free_fin_c = (info_r && (n_c != '0)) ? (n_c - COUNT_BITS'(1)) : n_c;
      end
      REQ_ALLOC: begin
        if (status_r == STAT_OK) begin
          free_fin_c = (cnt_r >= free_r) ? '0 : (free_r - cnt_r);
          res_c      = base_r + FRAME_NUMBER_BITS'(start_r);
        end
      end
      REQ_RESERVE: begin
        if (status_r == STAT_OK) begin
          free_fin_c = (cnt_r >= free_r) ? '0 : (free_r - cnt_r);
          res_c      = fno_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    free_nxt   = free_r;
    status_nxt = status_r;
    run_nxt    = run_r;
    start_nxt  = start_r;
    act_nxt    = act_r;
    end_nxt    = end_r;
    rd_ptr_nxt = rd_ptr_r;
    pw_nxt     = pw_r;
    pv_nxt     = cmd.step;
    if (cmd.step) begin
      rd_ptr_nxt = rd_ptr_r + WORD_BITS'(1);
      pw_nxt     = rd_ptr_r;
    end
    if (cmd.decide) begin
      status_nxt = pre_stat_c;
      run_nxt    = '0;
      act_nxt    = 1'b1;
      rd_ptr_nxt = (req_r == REQ_RELEASE) ? rel_r[IDX_BITS-1:LANE_BITS] : '0;
      if (req_r == REQ_RESERVE) begin
        start_nxt = rel_r;
      end
    end
    if (cmd.mark_setup) begin
      rd_ptr_nxt = start_r[IDX_BITS-1:LANE_BITS];
      end_nxt    = (end_sum_c < CMP_BITS'(n_c)) ? COUNT_BITS'(end_sum_c) : n_c;
    end
    if (proc_en_c) begin
      run_nxt   = run_c;
      start_nxt = start_c;
      act_nxt   = act_c;
      if (cmd.mode == SW_RELEASE) begin
        free_nxt = free_sum_c[COUNT_BITS] ? COUNT_MAX : free_sum_c[COUNT_BITS-1:0];
      end
      if (blocked_c) begin
        status_nxt = (cmd.mode == SW_MARK) ? STAT_NOTFREE : STAT_NOTHEAD;
      end else if ((cmd.mode == SW_SCAN) && word_done_c && !found_c) begin
        status_nxt = STAT_NOSPACE;
      end
    end
    if (cmd.finish) begin
      free_nxt = free_fin_c;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_frame_nxt  = out_frame_r;
    out_free_nxt   = out_free_r;
    if (cmd.finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_r;
      out_frame_nxt  = res_c;
      out_free_nxt   = free_fin_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RESET;
      pool_r      <= POOL_RESET;
      info_r      <= INFO_RESET;
      free_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      pool_r      <= pool_nxt;
      info_r      <= info_nxt;
      free_r      <= free_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    fno_r        <= fno_nxt;
    cnt_r        <= cnt_nxt;
    rel_r        <= rel_nxt;
    inr_r        <= inr_nxt;
    status_r     <= status_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    act_r        <= act_nxt;
    end_r        <= end_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    pw_r         <= pw_nxt;
    out_status_r <= out_status_nxt;
    out_frame_r  <= out_frame_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.result_frame = out_frame_r;
  assign out_ch.free_left    = out_free_r;

  assign sts.req      = req_r;
  assign sts.pre_done = (pre_stat_c != STAT_OK) || pre_skip_c;
  assign sts.done     = proc_en_c && word_done_c;
  assign sts.found    = found_c;
  assign sts.out_busy = out_valid_r && !out_ch.ready;

endmodule

`default_nettype wire

### rtl/core/contiguous_frame_allocator.sv
// contiguous_frame_allocator: top level, joins the sequencer and the datapath.
// depends on cfa_pkg, cfa_ifs, cfa_ctrl, cfa_dpath.
//
//   channel  | dir | handshake           | payload
//   in_ch    | in  | valid/ready         | req_type, frame_no, count
//   out_ch   | out | valid/ready         | status, result_frame, free_left
//   cfg_ch   | in  | valid/ready (ready=1) | index, data
//
// frame states sit in a ram of 8 frames per word; a sweep reads one word per
// cycle through the registered read port and writes it back once read out.
// failed checks go straight to the result; init and release sweep the words;
// reserve sets up its run and marks the words of the run; allocate scans
// words and, when a fit is found, sets up and marks the words of the run.
// reset clears the free count and loads the register defaults; no ram clear.
// a result held on out_ch does not block the next request; it stalls only the
// final step of the following one.
`default_nettype none

module contiguous_frame_allocator (
  input logic       clk,
  input logic       rst_n,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch,
  cfa_cfg_if.sink   cfg_ch
);
  import cfa_pkg::*;

  cfa_cmd_t cmd;
  cfa_sts_t sts;

  cfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cmd   (cmd),
    .sts   (sts)
  );

  cfa_dpath u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

`default_nettype wire

### rtl/core/cfa_checker.sv
// cfa_checker: port-level checks on the frame allocator, bound to the top level.
// depends on cfa_pkg.
`default_nettype none

module cfa_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [cfa_pkg::STATUS_BITS-1:0]       out_status,
  input logic [cfa_pkg::FRAME_NUMBER_BITS-1:0] out_result_frame,
  input logic [cfa_pkg::COUNT_BITS-1:0]        out_free_left
);
  import cfa_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_result_frame) && $stable(out_free_left))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= STAT_RANGE))
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> (out_result_frame == '0))
    else $error("failed request returned a frame");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

endmodule

bind contiguous_frame_allocator cfa_checker u_cfa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_status       (out_ch.status),
  .out_result_frame (out_ch.result_frame),
  .out_free_left    (out_ch.free_left)
);

`default_nettype wire

### test/tb_contiguous_frame_allocator.sv
// tb_contiguous_frame_allocator: self-checking bench for the frame allocator; a directed
// table and random request phases are scored, fixed rows against their own answer and
// the rest against a per-frame state predictor. depends on cfa_pkg, cfa_ifs and the rtl.
`default_nettype none

module tb_contiguous_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import cfa_pkg::*;

  typedef logic [FRAME_NUMBER_BITS-1:0] frame_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  typedef struct packed {
    stat_t  status;
    frame_t frame;
    count_t free_left;
  } answer_t;

  typedef struct {
    bit      is_cfg;
    req_t    rq;
    frame_t  fno;
    count_t  cnt;
    bit      fixed;
    answer_t want;
    frame_t  base_data;
    frame_t  pool_data;
    frame_t  info_data;
  } plan_row_t;

  localparam int STALL_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_HOLD    = 320;

  logic clk = 1'b0;
  logic rst_n;

  cfa_in_if  in_ch ();
  cfa_out_if out_ch ();
  cfa_cfg_if cfg_ch ();

  contiguous_frame_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  logic [ST_BITS-1:0] frame_map [MAX_FRAMES];
  int                 free_count;
  frame_t             pool_base;
  count_t             pool_len;
  logic               info_flag;

  answer_t   pending_answers [$];
  plan_row_t plan [$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  bit        feed_steady;

  function automatic int pool_limit();
    return (int'(pool_len) > MAX_FRAMES) ? MAX_FRAMES : int'(pool_len);
  endfunction

  function automatic bit frame_is_free(int f);
    return f < pool_limit() && frame_map[f] == ST_FREE;
  endfunction

  function automatic void take_frames(int n);
    free_count = (n >= free_count) ? 0 : free_count - n;
  endfunction

  function automatic void give_frame();
    if (free_count < int'(COUNT_MAX)) free_count++;
  endfunction

  function automatic void claim_run(int start, int n);
    int lim;
    int i;
    lim = pool_limit();
    if (start >= lim) return;
    frame_map[start] = ST_HEAD;
    for (i = 1; i < n && start + i < lim; i++) frame_map[start + i] = ST_USED;
  endfunction

  // pool offset of an absolute frame, -1 when outside the pool
  function automatic int pool_offset(frame_t fno);
    int fa;
    int fb;
    fa = int'(fno);
    fb = int'(pool_base);
    if (fa < fb || fa - fb >= pool_limit()) return -1;
    return fa - fb;
  endfunction

  function automatic answer_t serve_request(req_t rq, frame_t fno, count_t cnt);
    answer_t a;
    int n;
    int c;
    int f;
    int r;
    int run;
    int start;
    bit found;
    n = pool_limit();
    c = int'(cnt);
    a.status = STAT_OK;
    a.frame = '0;
    run = 0;
    start = 0;
    found = 1'b0;
    case (rq)
      REQ_INIT: begin
        for (f = 0; f < n; f++) frame_map[f] = ST_FREE;
        free_count = n;
        if (info_flag && n > 0) begin
          frame_map[0] = ST_HEAD;
          take_frames(1);
        end
      end
      REQ_ALLOC: begin
        if (c == 0) begin
          a.status = STAT_RANGE;
        end else if (c > free_count || c > n) begin
          a.status = STAT_NOSPACE;
        end else begin
          for (f = 0; f < n && !found; f++) begin
            if (frame_is_free(f)) begin
              if (run == 0) start = f;
              run++;
              if (run == c) found = 1'b1;
            end else begin
              run = 0;
            end
          end
          if (found) begin
            claim_run(start, c);
            take_frames(c);
            a.frame = frame_t'(pool_base + start);
          end else begin
            a.status = STAT_NOSPACE;
          end
        end
      end
      REQ_RESERVE: begin
        r = pool_offset(fno);
        if (c == 0 || r < 0) begin
          a.status = STAT_RANGE;
        end else if (!frame_is_free(r)) begin
          a.status = STAT_NOTFREE;
        end else begin
          claim_run(r, c);
          take_frames(c);
          a.frame = fno;
        end
      end
      default: begin
        r = pool_offset(fno);
        if (r < 0) begin
          a.status = STAT_RANGE;
        end else if (frame_map[r] != ST_HEAD) begin
          a.status = STAT_NOTHEAD;
        end else begin
          frame_map[r] = ST_FREE;
          give_frame();
          for (f = r + 1; f < n; f++) begin
            if (frame_map[f] == ST_FREE || frame_map[f] == ST_HEAD) break;
            frame_map[f] = ST_FREE;
            give_frame();
          end
        end
      end
    endcase
    a.free_left = count_t'(free_count);
    return a;
  endfunction

  function automatic int pick_head();
    int heads [$];
    int f;
    for (f = 0; f < pool_limit(); f++) begin
      if (frame_map[f] == ST_HEAD) heads.push_back(f);
    end
    if (heads.size() == 0) return -1;
    return heads[$urandom_range(0, heads.size() - 1)];
  endfunction

  function automatic count_t draw_count(int n);
    int cap;
    cap = n / 3;
    if (cap < 1) cap = 1;
    if (cap > 48) cap = 48;
    case ($urandom_range(0, 19))
      0: return '0;
      1: return count_t'($urandom);
      2: return count_t'(n);
      default: return count_t'($urandom_range(1, cap));
    endcase
  endfunction

  function automatic plan_row_t req_row(req_t rq, frame_t fno, count_t cnt);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.rq = rq;
    p.fno = fno;
    p.cnt = cnt;
    p.fixed = 1'b0;
    p.want = '0;
    p.base_data = '0;
    p.pool_data = '0;
    p.info_data = '0;
    return p;
  endfunction

  function automatic plan_row_t fixed_row(req_t rq, frame_t fno, count_t cnt,
                                          stat_t st, frame_t res, count_t left);
    plan_row_t p;
    p = req_row(rq, fno, cnt);
    p.fixed = 1'b1;
    p.want = '{status: st, frame: res, free_left: left};
    return p;
  endfunction

  function automatic plan_row_t cfg_row(frame_t b, frame_t p_data, frame_t i_data);
    plan_row_t p;
    p = req_row(REQ_ALLOC, '0, '0);
    p.is_cfg = 1'b1;
    p.base_data = b;
    p.pool_data = p_data;
    p.info_data = i_data;
    return p;
  endfunction

  task automatic send_request(req_t rq, frame_t fno, count_t cnt, bit fixed, answer_t want);
    int gap;
    answer_t outcome;
    if ($urandom_range(0, 15) == 0) feed_steady = !feed_steady;
    gap = feed_steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= rq;
    in_ch.frame_no <= fno;
    in_ch.count    <= cnt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    outcome = serve_request(rq, fno, cnt);
    pending_answers.push_back(fixed ? want : outcome);
  endtask

  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, frame_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      CFG_BASE: pool_base = data;
      CFG_POOL: pool_len  = data[COUNT_BITS-1:0];
      CFG_INFO: info_flag = data[0];
      default: ;
    endcase
  endtask

  task automatic reconfigure(frame_t b, frame_t p_data, frame_t i_data);
    wait_results_done();
    write_reg(CFG_BASE, b);
    write_reg(CFG_POOL, p_data);
    write_reg(CFG_INFO, i_data);
    cfg_ch.valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $error("result with no request outstanding: status %0d frame %0h free %0d",
               out_ch.status, out_ch.result_frame, out_ch.free_left);
        mismatches++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_ch.status !== exp_a.status) begin
          $error("status: expected %0d, got %0d", exp_a.status, out_ch.status);
          mismatches++;
        end
        if (out_ch.result_frame !== exp_a.frame) begin
          $error("result_frame: expected %0h, got %0h", exp_a.frame, out_ch.result_frame);
          mismatches++;
        end
        if (out_ch.free_left !== exp_a.free_left) begin
          $error("free_left: expected %0d, got %0d", exp_a.free_left, out_ch.free_left);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random back-pressure plus one long hold
  initial begin
    int gap;
    int taken;
    bit steady;
    bit held;
    taken = 0;
    steady = 1'b0;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) steady = !steady;
      gap = steady ? 0 : $urandom_range(0, 18);
      if (!held && taken == 60) begin
        gap = LONG_HOLD;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      taken++;
    end
  end

  initial begin
    int k;
    int n;
    int off;
    int items;
    int random_sent;
    int sel;
    bit big;
    req_t rq;
    frame_t fno;
    count_t cnt;
    frame_t b;
    frame_t p_data;
    answer_t none;

    none = '0;
    feed_steady = 1'b0;
    pool_base = BASE_RESET;
    pool_len = POOL_RESET;
    info_flag = INFO_RESET;
    free_count = 0;
    for (k = 0; k < MAX_FRAMES; k++) frame_map[k] = ST_FREE;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= REQ_ALLOC;
    in_ch.frame_no <= '0;
    in_ch.count    <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= CFG_BASE;
    cfg_ch.data    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state, pool end, zero count, outside frames, saturation
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd0,     STAT_RANGE,   20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd1,     STAT_NOSPACE, 20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_RELEASE, 20'hFFFFF, 15'd0,     STAT_RANGE,   20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_RESERVE, 20'd16384, 15'd1,     STAT_RANGE,   20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_INIT,    20'h00000, 15'd0,     STAT_OK,      20'h0, 15'd16383));
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd16384, STAT_NOSPACE, 20'h0, 15'd16383));
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd16383, STAT_OK,      20'h1, 15'd0));
    plan.push_back(fixed_row(REQ_RELEASE, 20'h00001, 15'd0,     STAT_OK,      20'h0, 15'd16383));
    plan.push_back(fixed_row(REQ_RELEASE, 20'h00000, 15'd0,     STAT_OK,      20'h0, 15'd16384));
    plan.push_back(fixed_row(REQ_RELEASE, 20'h00000, 15'd0,     STAT_NOTHEAD, 20'h0, 15'd16384));
    plan.push_back(fixed_row(REQ_RESERVE, 20'd16383, 15'h7FFF,  STAT_OK,      20'd16383, 15'd0));
    plan.push_back(fixed_row(REQ_RESERVE, 20'd16383, 15'd1,     STAT_NOTFREE, 20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd1,     STAT_NOSPACE, 20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_RELEASE, 20'd16383, 15'd0,     STAT_OK,      20'h0, 15'd1));
    // small pool at the top of the frame space, allocation wraps
    plan.push_back(cfg_row(20'hFFFF8, 20'hF0010, 20'hFFFFE));
    plan.push_back(fixed_row(REQ_INIT,    20'h00000, 15'd0,     STAT_OK,      20'h0, 15'd16));
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd10,    STAT_OK,      20'hFFFF8, 15'd6));
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd6,     STAT_OK,      20'h00002, 15'd0));
    plan.push_back(fixed_row(REQ_RESERVE, 20'h00002, 15'd1,     STAT_RANGE,   20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_RELEASE, 20'hFFFF8, 15'd0,     STAT_OK,      20'h0, 15'd10));
    plan.push_back(fixed_row(REQ_RESERVE, 20'hFFFFF, 15'd3,     STAT_OK,      20'hFFFFF, 15'd7));
    plan.push_back(req_row(REQ_ALLOC,     20'h00000, 15'd4));
    // reserve running over a head and used frames
    plan.push_back(req_row(REQ_RESERVE,   20'hFFFFE, 15'd3));
    // empty pool
    plan.push_back(cfg_row(20'hFFFF8, 20'h00000, 20'h00001));
    plan.push_back(fixed_row(REQ_INIT,    20'h00000, 15'd0,     STAT_OK,      20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_ALLOC,   20'h00000, 15'd1,     STAT_NOSPACE, 20'h0, 15'd0));
    plan.push_back(fixed_row(REQ_RESERVE, 20'hFFFF8, 15'd1,     STAT_RANGE,   20'h0, 15'd0));
    // oversized pool register acts as the full pool
    plan.push_back(cfg_row(20'h00000, 20'h07FFF, 20'h00001));
    plan.push_back(fixed_row(REQ_INIT,    20'h00000, 15'd0,     STAT_OK,      20'h0, 15'd16383));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        reconfigure(plan[i].base_data, plan[i].pool_data, plan[i].info_data);
      end else begin
        send_request(plan[i].rq, plan[i].fno, plan[i].cnt, plan[i].fixed, plan[i].want);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      big = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          p_data = $urandom_range(0, 1) ? 20'd16384 : 20'd32767;
          big = 1'b1;
        end
        1: p_data = frame_t'($urandom_range(0, 3));
        default: p_data = frame_t'($urandom_range(4, 80));
      endcase
      p_data[FRAME_NUMBER_BITS-1:COUNT_BITS] = (FRAME_NUMBER_BITS-COUNT_BITS)'($urandom);
      case ($urandom_range(0, 3))
        0: b = '0;
        1: b = '1;
        2: b = 20'hFFFFF - frame_t'($urandom_range(0, 40));
        default: b = frame_t'($urandom);
      endcase
      reconfigure(b, p_data, frame_t'($urandom));
      send_request(REQ_INIT, frame_t'($urandom), count_t'($urandom), 1'b0, none);
      random_sent++;
      items = big ? 16 : $urandom_range(20, 40);
      for (k = 0; k < items; k++) begin
        n = pool_limit();
        sel = $urandom_range(0, 99);
        fno = frame_t'($urandom);
        cnt = count_t'($urandom);
        if (sel < 6) begin
          rq = REQ_INIT;
        end else if (sel < 44) begin
          rq = REQ_ALLOC;
          cnt = draw_count(n);
        end else if (sel < 76) begin
          rq = REQ_RELEASE;
          off = pick_head();
          if (off >= 0 && $urandom_range(0, 4) != 0) begin
            fno = frame_t'(pool_base + off);
          end else if ($urandom_range(0, 1)) begin
            fno = frame_t'(pool_base + $urandom_range(0, n + 1));
          end
        end else begin
          rq = REQ_RESERVE;
          cnt = draw_count(n);
          if ($urandom_range(0, 9) < 7) begin
            fno = frame_t'(pool_base + $urandom_range(0, (n > 0) ? n - 1 : 0));
          end
        end
        send_request(rq, fno, cnt, 1'b0, none);
        random_sent++;
      end
    end

    wait_results_done();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### contiguous_frame_allocator.f
rtl/core/cfa_pkg.sv
rtl/core/cfa_ifs.sv
rtl/core/cfa_ram.sv
rtl/core/cfa_ctrl.sv
rtl/core/cfa_dpath.sv
rtl/core/contiguous_frame_allocator.sv
rtl/core/cfa_checker.sv
test/tb_contiguous_frame_allocator.sv
